### sv/murmur3_32_stream_hash_top_defines.svh
// Assertion macros for the RTL of the stream hash block, used by its top level.
`ifndef MURMUR3_32_STREAM_HASH_TOP_DEFINES_SVH
`define MURMUR3_32_STREAM_HASH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on the rising clock edge, disabled while in reset.
`define MM3_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("mm3 assertion failed");
// Check a property on the rising clock edge, also during reset.
`define MM3_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("mm3 assertion failed");
`else
`define MM3_ASSERT(label, clk, rst, prop)
`define MM3_ASSERT_NORST(label, clk, prop)
`endif

`endif

### sv/mm3_pkg.sv
`default_nettype none

package mm3_pkg;

   // Hash constants
   localparam logic [31:0] C1_MUL    = 32'hcc9e2d51;
   localparam logic [31:0] C2_MUL    = 32'h1b873593;
   localparam logic [31:0] ROUND_ADD = 32'he6546b64;
   localparam logic [31:0] FMIX_MUL1 = 32'h85ebca6b;
   localparam logic [31:0] FMIX_MUL2 = 32'hc2b2ae35;

   // Byte counts
   localparam logic [2:0] BYTES_NONE = 3'd0;
   localparam logic [2:0] BYTES_ONE  = 3'd1;
   localparam logic [2:0] BYTES_TWO  = 3'd2;
   localparam logic [2:0] BYTES_FULL = 3'd4;

   // Default depth of the queue between front and back
   localparam int QUEUE_DEPTH_DEF = 2;

   // Classified chunk as it travels through the queue
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  nbytes;
      logic        full;
      logic        last;
   } mm3_entry_type;

   // Back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCR2,
      BK_MIX,
      BK_FIN1,
      BK_FIN2
   } mm3_back_state_type;

   // Back end status seen by the top level
   typedef struct packed {
      mm3_back_state_type state;
      logic               in_key;
   } mm3_back_stat_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic empty;
   } mm3_queue_stat_type;

   // Low 32 bits of a 32 by 32 product
   function automatic logic [31:0] mm3_mul(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[31:0];
   endfunction

   // Rotate left by a constant amount
   function automatic logic [31:0] mm3_rotl(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

endpackage

`default_nettype wire

### sv/mm3_stream_ifs.sv
`default_nettype none

// Request channel: key chunks
interface mm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] chunk_word;
   logic [2:0]  chunk_bytes;
   logic        last_chunk;

   modport source (output valid, output chunk_word, output chunk_bytes,
                   output last_chunk, input ready);
   modport sink (input valid, input chunk_word, input chunk_bytes,
                 input last_chunk, output ready);
endinterface

// Response channel: finished hashes
interface mm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

### sv/mm3_queue.sv
`default_nettype none

module mm3_queue #(
   parameter int DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire mm3_pkg::mm3_entry_type push_entry,
   input  wire logic                   pop,
   output      logic                   q_valid,
   output      mm3_pkg::mm3_entry_type q_entry,
   output      mm3_pkg::mm3_queue_stat_type q_stat
);
   import mm3_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mm3_entry_type  mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign q_stat.full  = (count_ff == CW'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign q_valid      = !q_stat.empty;
   assign q_entry      = mem_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && q_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### sv/mm3_front.sv
`default_nettype none

module mm3_front (
   mm3_req_if.sink                     req_ch,
   input  wire mm3_pkg::mm3_queue_stat_type q_stat,
   output      logic                   push,
   output      mm3_pkg::mm3_entry_type push_entry
);
   import mm3_pkg::*;

   logic [2:0]  nb;
   logic [31:0] mask;
   logic        drop;

   // Clamp oversized counts to a full chunk
   assign nb = (req_ch.chunk_bytes > BYTES_FULL) ? BYTES_FULL : req_ch.chunk_bytes;

   // Mask the unused high bytes
   always_comb begin
      unique case (nb)
         BYTES_NONE: mask = 32'h00000000;
         BYTES_ONE:  mask = 32'h000000ff;
         BYTES_TWO:  mask = 32'h0000ffff;
         3'd3:       mask = 32'h00ffffff;
         default:    mask = 32'hffffffff;
      endcase
   end

   // Drop an empty chunk that does not close the key
   assign drop = (nb == BYTES_NONE) && !req_ch.last_chunk;

   assign push_entry.word   = req_ch.chunk_word & mask;
   assign push_entry.nbytes = nb;
   assign push_entry.full   = (nb == BYTES_FULL);
   assign push_entry.last   = req_ch.last_chunk || (nb != BYTES_FULL);

   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full && !drop;

endmodule

`default_nettype wire

### sv/mm3_back.sv
`default_nettype none

module mm3_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [31:0]            seed,
   input  wire logic                   q_valid,
   input  wire mm3_pkg::mm3_entry_type q_entry,
   output      logic                   pop,
   output      mm3_pkg::mm3_back_stat_type bk_stat,
   mm3_rsp_if.source                   rsp_ch
);
   import mm3_pkg::*;

   mm3_back_state_type state_ff, state_in;
   logic [31:0] k_ff, k_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] count_ff, count_in;
   logic        in_key_ff, in_key_in;
   logic        full_ff, full_in;
   logic        last_ff, last_in;
   logic [2:0]  nb_ff, nb_in;
   logic [31:0] f_ff, f_in;
   logic [31:0] out_ff, out_in;
   logic        out_valid_ff, out_valid_in;

   logic [31:0] base, h_x, h_r, h_m, h_new, cnt;
   logic [31:0] t1, t2, m2;

   // Mix terms for the current chunk
   always_comb begin
      base  = in_key_ff ? hash_ff : seed;
      h_x   = base ^ k_ff;
      h_r   = mm3_rotl(h_x, 13);
      h_m   = {h_r[29:0], 2'b00} + h_r + ROUND_ADD;
      h_new = full_ff ? h_m : h_x;
      cnt   = (in_key_ff ? count_ff : 32'd0) + {29'd0, nb_ff};
      t1    = f_ff ^ (f_ff >> 16);
      t2    = f_ff ^ (f_ff >> 13);
      m2    = mm3_mul(t2, FMIX_MUL2);
   end

   // Sequence one chunk through scramble and mix, and finalize after the last chunk
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      in_key_in    = in_key_ff;
      full_in      = full_ff;
      last_in      = last_ff;
      nb_in        = nb_ff;
      f_in         = f_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               k_in     = mm3_mul(q_entry.word, C1_MUL);
               full_in  = q_entry.full;
               last_in  = q_entry.last;
               nb_in    = q_entry.nbytes;
               state_in = BK_SCR2;
            end
         end
         BK_SCR2: begin
            k_in     = mm3_mul(mm3_rotl(k_ff, 15), C2_MUL);
            state_in = BK_MIX;
         end
         BK_MIX: begin
            if (last_ff) begin
               f_in      = h_new ^ cnt;
               in_key_in = 1'b0;
               count_in  = 32'd0;
               state_in  = BK_FIN1;
            end else begin
               hash_in   = h_new;
               count_in  = cnt;
               in_key_in = 1'b1;
               state_in  = BK_IDLE;
            end
         end
         BK_FIN1: begin
            f_in     = mm3_mul(t1, FMIX_MUL1);
            state_in = BK_FIN2;
         end
         BK_FIN2: begin
            // Hold until the output register is free
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in       = m2 ^ (m2 >> 16);
               out_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         in_key_ff    <= 1'b0;
         count_ff     <= 32'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      hash_ff <= hash_in;
      full_ff <= full_in;
      last_ff <= last_in;
      nb_ff   <= nb_in;
      f_ff    <= f_in;
      out_ff  <= out_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.hash_value = out_ff;
   assign bk_stat.state     = state_ff;
   assign bk_stat.in_key    = in_key_ff;

endmodule

`default_nettype wire

### sv/murmur3_32_stream_hash_top.sv
// Streaming 32-bit MurmurHash3.
// Requests on req_ch carry one little-endian key chunk each: chunk_word,
// chunk_bytes (0 to 4, larger counts act as 4) and last_chunk. A chunk with
// fewer than four bytes closes the key; an empty chunk that is not last is
// taken and dropped. Each key gives one hash_value on rsp_ch.
// The seed register sits at csr addresses 0 to 3 and applies from the next
// key on, or at once when no chunk of the key has been mixed yet.
// Flow: the front classifies a request into a queue in the accepting
// cycle; the back sequencer takes each chunk through scramble multiply,
// second multiply and mix, and pops the next chunk only after the mix; after
// the last chunk of a key the final avalanche multiplies run before the hash
// is loaded into the output register.
// A stalled response holds in the output register while the back keeps
// working on the next key; it stops only when a second hash is ready.
// Requests stall once the queue is full.
// Reset clears the queue, the key state, the output valid and the seed.

`default_nettype none

`include "murmur3_32_stream_hash_top_defines.svh"

module murmur3_32_stream_hash_top #(
   parameter int QUEUE_DEPTH = mm3_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mm3_req_if.sink          req_ch,
   mm3_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import mm3_pkg::*;

   logic [31:0]        seed_reg_ff;
   logic               push, pop, q_valid;
   mm3_entry_type      push_entry, q_entry;
   mm3_queue_stat_type q_stat;
   mm3_back_stat_type  bk_stat;

   // Seed register write and read back
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? seed_reg_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_reg_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == 1'b0)) begin
         seed_reg_ff <= csr_pwdata;
      end
   end

   mm3_front u_front (
      .req_ch     (req_ch),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   mm3_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_stat     (q_stat)
   );

   mm3_back u_back (
      .clock   (clock),
      .reset   (reset),
      .seed    (seed_reg_ff),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .pop     (pop),
      .bk_stat (bk_stat),
      .rsp_ch  (rsp_ch)
   );

   // No response is offered right after reset
   `MM3_ASSERT_NORST(a_rsp_clear_after_reset, clock, reset |=> !rsp_ch.valid)
   // A queued chunk is picked up by an idle back end
   `MM3_ASSERT(a_pick_up, clock, reset,
      (q_valid && bk_stat.state == BK_IDLE) |=> (bk_stat.state == BK_SCR2))
   // Finalize waits while the output register is blocked
   `MM3_ASSERT(a_fin_hold, clock, reset,
      (bk_stat.state == BK_FIN2 && rsp_ch.valid && !rsp_ch.ready)
      |=> (bk_stat.state == BK_FIN2))
   // The queue never reads full and empty at once
   `MM3_ASSERT(a_queue_sane, clock, reset, !(q_stat.full && q_stat.empty))

endmodule

`default_nettype wire
